>>> src/cht_pkg.sv
// Shared types and constants of the chained hash table unit.
// Depends on nothing; every other file imports it.
package cht_pkg;

    localparam int KEY_W          = 31;
    localparam int CFG_W          = 7;
    localparam int BUCKET_W       = 6;
    localparam int REM_W          = 7;
    localparam int DVD_W          = 32;
    localparam int DIV_STEPS      = 16;
    localparam int DIV_CNT_W      = 4;
    localparam int DEF_BUCKETS    = 64;
    localparam int DEF_POOL       = 128;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t              kind;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        status_t             status;
        logic [BUCKET_W-1:0] bucket;
    } out_word_t;

endpackage

>>> src/chained_hash_table_unit.sv
// Steps: an accepted word passes through the 2-bit-per-cycle remainder unit (S_DIV), then the
// bucket read (S_BREAD, S_BCHK), which ends an insert into an empty bucket or a refused insert;
// an insert into a bucket with a chain adds a link fix (S_NFIX), a search one read per node (S_NCMP).
// One word at a time: busy falls as the strobe rises, so the next word can be accepted while
// the strobe is high. The receiver cannot stall; the result strobe is high for a single cycle.
// After reset a clearing pass writes every bucket entry empty, with busy high.
module chained_hash_table_unit
    import cht_pkg::*;
#(
    parameter int BUCKETS      = DEF_BUCKETS,
    parameter int POOL_ENTRIES = DEF_POOL
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_word_t         item,
    output logic             done,
    output out_word_t        result,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int PW = $clog2(POOL_ENTRIES + 1);
    localparam int NW = $clog2(POOL_ENTRIES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [PW-1:0] MARK = PW'(POOL_ENTRIES);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
    } bkt_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PW-1:0]    next;
    } node_word_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_BREAD = 7'b0001000,
        S_BCHK  = 7'b0010000,
        S_NFIX  = 7'b0100000,
        S_NCMP  = 7'b1000000
    } state_t;

    bkt_word_t  bkt_mem [BUCKETS];
    node_word_t node_mem [POOL_ENTRIES];

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     bc_reg, bc_next;
    logic [CFG_W-1:0]     div_reg, div_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    op_t                  kind_reg, kind_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PW-1:0]        used_reg, used_next;
    logic [PW-1:0]        ptr_reg, ptr_next;
    logic [BW-1:0]        clr_reg, clr_next;
    logic                 done_reg, done_next;
    status_t              status_reg, status_next;
    logic [BUCKET_W-1:0]  bucket_reg, bucket_next;

    logic              bkt_we, bkt_re;
    logic [BW-1:0]     bkt_waddr, bkt_raddr;
    bkt_word_t         bkt_wdata, bkt_rdata;
    logic              node_we, node_re;
    logic [NW-1:0]     node_waddr, node_raddr;
    node_word_t        node_wdata, node_rdata;

    logic [CFG_W-1:0]  active;
    logic [REM_W:0]    r1, r2;
    logic [BW-1:0]     bidx;

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re)
        begin
            bkt_rdata <= bkt_mem[bkt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rdata <= node_mem[node_raddr];
        end
    end

    always_comb
    begin
        if (bc_reg == '0)
        begin
            active = CFG_W'(1);
        end
        else if (32'(bc_reg) > 32'(BUCKETS))
        begin
            active = CFG_W'(BUCKETS);
        end
        else
        begin
            active = bc_reg;
        end
    end

    always_comb
    begin
        r1 = {rem_reg, dvd_reg[DVD_W-1]};
        if (r1 >= {1'b0, div_reg})
        begin
            r1 = r1 - {1'b0, div_reg};
        end
        r2 = {r1[REM_W-1:0], dvd_reg[DVD_W-2]};
        if (r2 >= {1'b0, div_reg})
        begin
            r2 = r2 - {1'b0, div_reg};
        end
    end

    assign bidx = BW'(rem_reg);

    always_comb
    begin
        state_next  = state_reg;
        bc_next     = cfg_we ? cfg_data : bc_reg;
        div_next    = div_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        used_next   = used_reg;
        ptr_next    = ptr_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        bucket_next = bucket_reg;
        bkt_we      = 1'b0;
        bkt_re      = 1'b0;
        bkt_waddr   = bidx;
        bkt_raddr   = bidx;
        bkt_wdata   = '{head: MARK, tail: MARK};
        node_we     = 1'b0;
        node_re     = 1'b0;
        node_waddr  = used_reg[NW-1:0];
        node_raddr  = bkt_rdata.head[NW-1:0];
        node_wdata  = '{key: key_reg, next: MARK};

        unique case (state_reg)
            S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                clr_next  = clr_reg + BW'(1);
                if (clr_reg == LAST_BKT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = item.kind;
                    key_next   = item.key;
                    dvd_next   = {1'b0, item.key};
                    rem_next   = '0;
                    cnt_next   = '0;
                    div_next   = active;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = r2[REM_W-1:0];
                dvd_next = {dvd_reg[DVD_W-3:0], 2'b00};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_BREAD;
                end
            end
            S_BREAD:
            begin
                bkt_re     = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                bucket_next = rem_reg[BUCKET_W-1:0];
                if (kind_reg == OP_INSERT)
                begin
                    if (used_reg == MARK)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FULL;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        node_we   = 1'b1;
                        bkt_we    = 1'b1;
                        used_next = used_reg + PW'(1);
                        if (bkt_rdata.tail < used_reg)
                        begin
                            bkt_wdata  = '{head: bkt_rdata.head, tail: used_reg};
                            node_re    = 1'b1;
                            node_raddr = bkt_rdata.tail[NW-1:0];
                            ptr_next   = bkt_rdata.tail;
                            state_next = S_NFIX;
                        end
                        else
                        begin
                            bkt_wdata   = '{head: used_reg, tail: used_reg};
                            done_next   = 1'b1;
                            status_next = ST_INSERTED;
                            state_next  = S_IDLE;
                        end
                    end
                end
                else
                begin
                    if (bkt_rdata.head < used_reg)
                    begin
                        node_re    = 1'b1;
                        node_raddr = bkt_rdata.head[NW-1:0];
                        state_next = S_NCMP;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISSING;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_NFIX:
            begin
                node_we     = 1'b1;
                node_waddr  = ptr_reg[NW-1:0];
                node_wdata  = '{key: node_rdata.key, next: used_reg - PW'(1)};
                done_next   = 1'b1;
                status_next = ST_INSERTED;
                state_next  = S_IDLE;
            end
            S_NCMP:
            begin
                if (node_rdata.key == key_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FOUND;
                    state_next  = S_IDLE;
                end
                else if (node_rdata.next < used_reg)
                begin
                    node_re    = 1'b1;
                    node_raddr = node_rdata.next[NW-1:0];
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_MISSING;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            bc_reg    <= CFG_RESET;
            used_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bc_reg    <= bc_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg    <= div_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        bucket_reg <= bucket_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result.status = status_reg;
    assign result.bucket = bucket_reg;

endmodule

>>> src/cht_checker.sv
// Port-level checks for the chained hash table unit, bound to its top level.
// Depends on cht_pkg for the result word type.
module cht_checker
    import cht_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t result
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a word was accepted");

    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe in the cycle after an accept");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("result word appeared without work in progress");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("result word has unknown bits while the strobe is high");

endmodule

bind chained_hash_table_unit cht_checker u_cht_checker (.*);
